[hdl/dnq_pkg.sv]
// Package for the deduplicating notice queue: widths, command codes, types.
// No dependencies.
`default_nettype none
package dnq_pkg;
  localparam int unsigned HistDepth  = 64;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned KeyBits    = 32;
  localparam int unsigned HistIdxW   = $clog2(HistDepth);
  localparam int unsigned QIdxW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    CmdEnqueue = 2'd0,
    CmdTick    = 2'd1,
    CmdDismiss = 2'd2,
    CmdClear   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StSearch = 4'b0010,
    StApply  = 4'b0100,
    StOut    = 4'b1000
  } state_e;

  localparam logic RegQueueLimit = 1'b0;
  localparam logic RegCooldown   = 1'b1;

  // Control handed from the sequencer to each cell of the key chain.
  typedef struct packed {
    logic clear;
    logic shift;
    logic search;
  } cell_ctl_t;
endpackage
`default_nettype wire

[hdl/dnq_key_cell.sv]
// One cell of the history key chain: holds one key and its valid bit.
// Depends on dnq_pkg.
`default_nettype none
module dnq_key_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire dnq_pkg::cell_ctl_t         ctl_i,
  input  wire logic [dnq_pkg::KeyBits-1:0] key_i,
  input  wire logic                       vld_i,
  input  wire logic [dnq_pkg::KeyBits-1:0] probe_i,
  output logic      [dnq_pkg::KeyBits-1:0] key_o,
  output logic                            vld_o,
  output logic                            hit_o
);
  logic [dnq_pkg::KeyBits-1:0] key_q;
  logic vld_q;

  // Shift the key in from the neighbor; the valid bit rides along and is cleared by reset or clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctl_i.shift) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) key_q <= key_i;
  end

  assign key_o = key_q;
  assign vld_o = vld_q;
  assign hit_o = ctl_i.search & vld_q & (key_q == probe_i);
endmodule
`default_nettype wire

[hdl/dedup_notice_queue_with_cooldown_top.sv]
// Top level of the deduplicating notice queue with display cooldown.
// Depends on dnq_pkg and dnq_key_cell.
//
//  Channel | Handshake          | Payload
//  in      | in_valid/in_stall  | cmd, item_ok, item_key, show_ms, now_ms, flags
//  out     | out_valid/out_stall| accepted .. pending_count
//  cfg     | cfg_we_i           | cfg_idx_i, cfg_data_i
// Each item passes capture, one parallel compare over the history chain and the
// pending queue, update, and the result register, in that order. The chain of 64
// cells compares all its keys at once and shifts a new key in on accept. Reset clears
// all control state; no clearing pass is needed. Input stalls while an item is in
// flight or its result waits.
`default_nettype none
module dedup_notice_queue_with_cooldown_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic        item_ok_i,
  input  wire logic [31:0] item_key_i,
  input  wire logic [31:0] show_ms_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        blocked_i,
  input  wire logic        paused_i,
  input  wire logic        partner_ready_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             accepted_o,
  output logic             dropped_oldest_o,
  output logic             expired_o,
  output logic             started_o,
  output logic             active_valid_o,
  output logic [31:0]      active_key_o,
  output logic [4:0]       pending_count_o
);
  localparam int unsigned HD = dnq_pkg::HistDepth;
  localparam int unsigned QD = dnq_pkg::QueueDepth;
  localparam int unsigned KB = dnq_pkg::KeyBits;

  dnq_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [4:0]  qlim_q;
  logic [31:0] cool_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlim_q <= 5'd4;
      cool_q <= 32'd10000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dnq_pkg::RegQueueLimit) qlim_q <= cfg_data_i[4:0];
      else cool_q <= cfg_data_i;
    end
  end

  // Captured input beat.
  logic [1:0]    cmd_q;
  logic          ok_q, blk_q, pau_q, rdy_q;
  logic [KB-1:0] key_q;
  logic [31:0]   show_q, now_q;
  logic          in_acc;
  assign in_acc = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != dnq_pkg::StIdle);
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i; ok_q <= item_ok_i; key_q <= item_key_i[KB-1:0];
      show_q <= show_ms_i; now_q <= now_ms_i;
      blk_q <= blocked_i; pau_q <= paused_i; rdy_q <= partner_ready_i;
    end
  end

  // History chain of cells; cell 0 takes the new key, the last one falls off.
  dnq_pkg::cell_ctl_t ctl;
  logic [KB-1:0] ck [HD+1];
  logic          cv [HD+1];
  logic [HD-1:0] hits;
  logic          acc_now;
  assign ck[0] = key_q;
  assign cv[0] = 1'b1;
  for (genvar g = 0; g < HD; g++) begin : g_cell
    dnq_key_cell u_cell (
      .clk_i, .rst_ni, .ctl_i(ctl), .key_i(ck[g]), .vld_i(cv[g]),
      .probe_i(key_q), .key_o(ck[g+1]), .vld_o(cv[g+1]), .hit_o(hits[g])
    );
  end

  // Pending queue.
  logic [KB-1:0]  pk_q [QD];
  logic [31:0]    pd_q [QD];
  logic [dnq_pkg::QIdxW-1:0] head_q;
  logic [dnq_pkg::QCntW-1:0] fill_q;
  logic [QD-1:0]  phit;
  always_comb begin
    for (int i = 0; i < QD; i++) begin
      phit[i] = (pk_q[i] == key_q) &&
        ((dnq_pkg::QIdxW'(i) - head_q) < dnq_pkg::QIdxW'(fill_q)
         || fill_q == dnq_pkg::QCntW'(QD));
    end
  end

  logic          act_q;
  logic [KB-1:0] aid_q;
  logic [31:0]   vdl_q, cdl_q;
  logic          known_q;

  always_ff @(posedge clk_i) begin
    if (state_q == dnq_pkg::StSearch)
      known_q <= (|hits) | (|phit) | (act_q & (aid_q == key_q));
  end

  assign acc_now = (state_q == dnq_pkg::StApply) &&
                   (cmd_q == dnq_pkg::CmdEnqueue) && ok_q && !known_q;
  assign ctl.search = (state_q == dnq_pkg::StSearch);
  assign ctl.shift  = acc_now;
  assign ctl.clear  = (state_q == dnq_pkg::StApply) && (cmd_q == dnq_pkg::CmdClear);

  // Effective limit.
  logic [dnq_pkg::QCntW-1:0] lim;
  always_comb begin
    if (qlim_q == 5'd0) lim = dnq_pkg::QCntW'(1);
    else if (32'(qlim_q) > QD) lim = dnq_pkg::QCntW'(QD);
    else lim = dnq_pkg::QCntW'(qlim_q);
  end

  logic [32:0] vsum, csum;
  assign vsum = {1'b0, now_q} + {1'b0, pd_q[head_q]};
  assign csum = {1'b0, now_q} + {1'b0, cool_q};

  logic r_acc, r_drop, r_exp, r_start;
  logic exp_c, start_c, drop_c;
  logic [dnq_pkg::QIdxW-1:0] h2;
  logic [dnq_pkg::QCntW-1:0] f2;
  always_comb begin
    drop_c = acc_now && (fill_q >= lim);
    h2 = drop_c ? head_q + 1'b1 : head_q;
    f2 = drop_c ? fill_q - 1'b1 : fill_q;
    exp_c = (cmd_q == dnq_pkg::CmdTick) && act_q && (now_q >= vdl_q);
    start_c = (cmd_q == dnq_pkg::CmdTick) && (!act_q || exp_c) && (fill_q != '0)
              && !blk_q && !pau_q && (now_q >= cdl_q) && rdy_q;
  end

  // Queue, active slot and deadlines.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0; fill_q <= '0; act_q <= 1'b0; aid_q <= '0;
      vdl_q <= '0; cdl_q <= '0;
      r_acc <= 1'b0; r_drop <= 1'b0; r_exp <= 1'b0; r_start <= 1'b0;
    end else if (state_q == dnq_pkg::StApply) begin
      r_acc <= acc_now; r_drop <= drop_c; r_exp <= exp_c; r_start <= start_c;
      unique case (cmd_q)
        dnq_pkg::CmdEnqueue: begin
          if (acc_now) begin
            head_q <= h2;
            fill_q <= f2 + 1'b1;
          end
        end
        dnq_pkg::CmdTick: begin
          if (exp_c) begin
            act_q <= 1'b0; aid_q <= '0; vdl_q <= '0;
          end
          if (start_c) begin
            act_q <= 1'b1; aid_q <= pk_q[head_q];
            vdl_q <= vsum[32] ? '1 : vsum[31:0];
            cdl_q <= csum[32] ? '1 : csum[31:0];
            head_q <= head_q + 1'b1; fill_q <= fill_q - 1'b1;
          end
        end
        dnq_pkg::CmdDismiss: begin
          act_q <= 1'b0; aid_q <= '0; vdl_q <= '0;
        end
        dnq_pkg::CmdClear: begin
          head_q <= '0; fill_q <= '0; act_q <= 1'b0; aid_q <= '0;
          vdl_q <= '0; cdl_q <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_now) begin
      pk_q[h2 + dnq_pkg::QIdxW'(f2)] <= key_q;
      pd_q[h2 + dnq_pkg::QIdxW'(f2)] <= show_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dnq_pkg::StIdle:   if (in_acc) state_d = dnq_pkg::StSearch;
      dnq_pkg::StSearch: state_d = dnq_pkg::StApply;
      dnq_pkg::StApply:  state_d = dnq_pkg::StOut;
      dnq_pkg::StOut:    if (!out_stall_i) state_d = dnq_pkg::StIdle;
      default:           state_d = dnq_pkg::StIdle;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= dnq_pkg::StIdle;
    else state_q <= state_d;
  end

  assign out_valid_o      = (state_q == dnq_pkg::StOut);
  assign accepted_o       = r_acc;
  assign dropped_oldest_o = r_drop;
  assign expired_o        = r_exp;
  assign started_o        = r_start;
  assign active_valid_o   = act_q;
  assign active_key_o     = act_q ? 32'(aid_q) : 32'd0;
  assign pending_count_o  = 5'(fill_q);
endmodule
`default_nettype wire

[hdl/dnq_checker.sv]
// Port-level checker for the notice queue top level, with its bind.
// Depends on dedup_notice_queue_with_cooldown_top.
`default_nettype none
module dnq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic        accepted_o,
  input wire logic        started_o,
  input wire logic        active_valid_o,
  input wire logic [31:0] active_key_o,
  input wire logic [4:0]  pending_count_o
);
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open while result waits");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result beat lost");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && started_o |-> active_valid_o) else $error("start without active");
  a_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_valid_o |-> active_key_o == 32'd0) else $error("stale key");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && accepted_o |-> pending_count_o != 5'd0) else $error("empty after accept");
endmodule

bind dedup_notice_queue_with_cooldown_top dnq_checker u_dnq_checker (.*);
`default_nettype wire
